// ===== rtl/lpg_pkg.sv =====
package lpg_pkg;

	localparam int TIME_BITS = 48;
	localparam int HALF_W    = 16;
	localparam int PAT_W     = 3;
	localparam int PHASE_W   = 3;
	localparam int PULSE_W   = 2;
	localparam int MS_W      = 10;
	localparam int PROD_W    = HALF_W + MS_W;
	localparam int CNT_W     = $clog2(TIME_BITS + 1);
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = 3;

	localparam logic [MS_W-1:0] US_PER_MS = MS_W'(1000);

	// whole milliseconds of a leftover below 2^26 us: drop 3 bits, then
	// multiply by ceil(2^30 / 125) and keep bits 30 and up
	localparam int REC_DROP = 3;
	localparam int REC_IN_W = PROD_W - REC_DROP;
	localparam int REC_W    = 24;
	localparam int REC_P_W  = REC_IN_W + REC_W;
	localparam int REC_SH   = 30;
	localparam logic [REC_W-1:0] RECIP_125 = 24'd8589935;

	// pattern codes
	localparam logic [PAT_W-1:0] PAT_ON        = 3'd0;
	localparam logic [PAT_W-1:0] PAT_OFF       = 3'd1;
	localparam logic [PAT_W-1:0] PAT_SLOW      = 3'd2;
	localparam logic [PAT_W-1:0] PAT_MEDIUM    = 3'd3;
	localparam logic [PAT_W-1:0] PAT_FAST      = 3'd4;
	localparam logic [PAT_W-1:0] PAT_VERY_FAST = 3'd5;
	localparam logic [PAT_W-1:0] PAT_FLASH3    = 3'd6;
	localparam logic [PAT_W-1:0] PAT_FLASH2    = 3'd7;

	localparam logic [PULSE_W-1:0] PULSES_FLASH3 = 2'd3;
	localparam logic [PULSE_W-1:0] PULSES_FLASH2 = 2'd2;

	// action codes
	localparam logic ACT_SELECT = 1'b0;
	localparam logic ACT_POLL   = 1'b1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SLOW      = 3'd0;
	localparam logic [IDX_W-1:0] REG_MEDIUM    = 3'd1;
	localparam logic [IDX_W-1:0] REG_FAST      = 3'd2;
	localparam logic [IDX_W-1:0] REG_VERY_FAST = 3'd3;
	localparam logic [IDX_W-1:0] REG_FLASH     = 3'd4;

	localparam logic [HALF_W-1:0] SLOW_RST      = 16'd400;
	localparam logic [HALF_W-1:0] MEDIUM_RST    = 16'd200;
	localparam logic [HALF_W-1:0] FAST_RST      = 16'd100;
	localparam logic [HALF_W-1:0] VERY_FAST_RST = 16'd50;
	localparam logic [HALF_W-1:0] FLASH_RST     = 16'd80;

	typedef struct packed {
		logic                 action;
		logic [PAT_W-1:0]     pattern;
		logic [TIME_BITS-1:0] now_us;
	} in_word_t;

	typedef struct packed {
		logic             led_on;
		logic [PAT_W-1:0] active_pattern;
		logic             flashing;
	} out_word_t;

	typedef struct packed {
		logic [HALF_W-1:0] slow_half_ms;
		logic [HALF_W-1:0] medium_half_ms;
		logic [HALF_W-1:0] fast_half_ms;
		logic [HALF_W-1:0] very_fast_half_ms;
		logic [HALF_W-1:0] flash_half_ms;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic load;
		logic do_select;
		logic span_load;
		logic flash_step;
		logic div_start;
		logic ms_calc;
		logic mul;
		logic toggle;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic is_static;
		logic in_flash;
		logic div_done;
		logic elapsed_ge;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/led_pattern_generator_unit.sv =====
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+---------------------------------------
// in       | input     | in_valid / in_stall | in_word_t: action, pattern, now_us
// out      | output    | out_valid/out_stall | out_word_t: led_on, active_pattern,
//          |           |                     |             flashing
// apb      | input     | psel/penable/pready | five 16-bit half periods at 4*i
//
// A selection word, or a poll in solid on or off, goes from S_DECIDE to S_FINISH and is
// loaded into the output register there once that register is free; a poll in a blink or
// flash passes S_CHECK on the way. A blink that re-arms runs a 48-step radix-2 divide by
// the half period in microseconds and turns the leftover into whole milliseconds by a
// reciprocal multiply. in_stall is high from the accept until the result is loaded, so
// the next word can enter in the cycle after; while a result waits on out_stall the next
// word still enters. Reset restores the default half periods, solid on with the LED lit,
// and an empty output register.
module led_pattern_generator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lpg_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lpg_pkg::out_word_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpg_pkg::ADDR_W-1:0]    paddr,
	input  logic [lpg_pkg::DATA_W-1:0]    pwdata,
	output logic [lpg_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	lpg_pkg::cfg_t      cfg_q;
	lpg_pkg::cmd_t      cmd;
	lpg_pkg::status_t   dp_status;
	lpg_pkg::status_t   status;
	lpg_pkg::out_word_t result;
	lpg_pkg::out_word_t out_data_q;
	logic               out_valid_q;
	logic               cfg_wr;
	logic [lpg_pkg::IDX_W-1:0]  cfg_idx;
	logic [lpg_pkg::HALF_W-1:0] rd_val;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[lpg_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_half_ms      <= lpg_pkg::SLOW_RST;
			cfg_q.medium_half_ms    <= lpg_pkg::MEDIUM_RST;
			cfg_q.fast_half_ms      <= lpg_pkg::FAST_RST;
			cfg_q.very_fast_half_ms <= lpg_pkg::VERY_FAST_RST;
			cfg_q.flash_half_ms     <= lpg_pkg::FLASH_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				lpg_pkg::REG_SLOW:      cfg_q.slow_half_ms      <= pwdata[lpg_pkg::HALF_W-1:0];
				lpg_pkg::REG_MEDIUM:    cfg_q.medium_half_ms    <= pwdata[lpg_pkg::HALF_W-1:0];
				lpg_pkg::REG_FAST:      cfg_q.fast_half_ms      <= pwdata[lpg_pkg::HALF_W-1:0];
				lpg_pkg::REG_VERY_FAST: cfg_q.very_fast_half_ms <= pwdata[lpg_pkg::HALF_W-1:0];
				lpg_pkg::REG_FLASH:     cfg_q.flash_half_ms     <= pwdata[lpg_pkg::HALF_W-1:0];
				default: ;  // drop writes outside the register list
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			lpg_pkg::REG_SLOW:      rd_val = cfg_q.slow_half_ms;
			lpg_pkg::REG_MEDIUM:    rd_val = cfg_q.medium_half_ms;
			lpg_pkg::REG_FAST:      rd_val = cfg_q.fast_half_ms;
			lpg_pkg::REG_VERY_FAST: rd_val = cfg_q.very_fast_half_ms;
			lpg_pkg::REG_FLASH:     rd_val = cfg_q.flash_half_ms;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = lpg_pkg::DATA_W'(rd_val);

	// ---------------- controller and datapath ----------------
	// the output register's room is known only here: merge it into the status
	always_comb begin
		status          = dp_status;
		status.out_free = !out_valid_q || !out_stall;
	end

	lpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd)
	);

	lpg_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_data (in_data),
		.cmd     (cmd),
		.status  (dp_status),
		.result  (result)
	);

	// stall the input whenever a word is in work
	assign in_stall = !cmd.idle;

	// ---------------- output register ----------------
	// hold a finished word until taken; refill in the cycle it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/lpg_divider.sv =====
module lpg_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lpg_pkg::TIME_BITS-1:0]  dividend,
	input  logic [lpg_pkg::PROD_W-1:0]     divisor,
	output logic [lpg_pkg::PROD_W-1:0]     remainder,
	output logic                           done
);

	logic [lpg_pkg::TIME_BITS-1:0] quo_q;
	logic [lpg_pkg::PROD_W-1:0]    rem_q;
	logic [lpg_pkg::PROD_W-1:0]    dvs_q;
	logic [lpg_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lpg_pkg::PROD_W:0]      partial;
	logic [lpg_pkg::PROD_W:0]      trial;
	logic                          fits;

	// one restoring step: bring down the next dividend bit, try the subtract
	assign partial = {rem_q, quo_q[lpg_pkg::TIME_BITS-1]};
	assign trial   = partial - {1'b0, dvs_q};
	assign fits    = (partial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lpg_pkg::CNT_W'(lpg_pkg::TIME_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - lpg_pkg::CNT_W'(1);
				if (cnt_q == lpg_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[lpg_pkg::TIME_BITS-2:0], fits};
			rem_q <= fits ? trial[lpg_pkg::PROD_W-1:0] : partial[lpg_pkg::PROD_W-1:0];
		end
	end

	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ===== rtl/lpg_datapath.sv =====
module lpg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lpg_pkg::cfg_t       cfg,
	input  lpg_pkg::in_word_t   in_data,
	input  lpg_pkg::cmd_t       cmd,
	output lpg_pkg::status_t    status,
	output lpg_pkg::out_word_t  result
);

	// latched item
	logic                          act_q;
	logic [lpg_pkg::PAT_W-1:0]     req_pat_q;
	logic [lpg_pkg::TIME_BITS-1:0] now_q;

	// generator state
	logic [lpg_pkg::PAT_W-1:0]     pat_q;
	logic [lpg_pkg::TIME_BITS-1:0] last_q;
	logic                          led_q;
	logic                          flash_q;
	logic [lpg_pkg::PULSE_W-1:0]   pulses_q;
	logic [lpg_pkg::PHASE_W-1:0]   phase_q;

	// half period in microseconds, leftover milliseconds and their microseconds
	logic [lpg_pkg::PROD_W-1:0]    span_q;
	logic [lpg_pkg::HALF_W-1:0]    ms_q;
	logic [lpg_pkg::PROD_W-1:0]    prod_q;

	logic [lpg_pkg::HALF_W-1:0]    half_raw;
	logic [lpg_pkg::HALF_W-1:0]    half_eff;
	logic [lpg_pkg::TIME_BITS-1:0] diff;
	logic [lpg_pkg::PROD_W-1:0]    remainder;
	logic                          div_done;
	logic [lpg_pkg::REC_P_W-1:0]   rec_prod;
	logic [lpg_pkg::PHASE_W-1:0]   next_phase;
	logic                          same_pat;

	always_comb begin
		case (pat_q)
			lpg_pkg::PAT_SLOW:      half_raw = cfg.slow_half_ms;
			lpg_pkg::PAT_MEDIUM:    half_raw = cfg.medium_half_ms;
			lpg_pkg::PAT_FAST:      half_raw = cfg.fast_half_ms;
			lpg_pkg::PAT_VERY_FAST: half_raw = cfg.very_fast_half_ms;
			default:                half_raw = cfg.flash_half_ms;
		endcase
	end

	// zero reads as one millisecond
	assign half_eff = (half_raw == '0) ? lpg_pkg::HALF_W'(1) : half_raw;

	assign diff = now_q - last_q;

	// elapsed ms mod half equals whole ms of (elapsed us mod half-period us)
	lpg_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (diff),
		.divisor   (span_q),
		.remainder (remainder),
		.done      (div_done)
	);

	assign rec_prod = lpg_pkg::REC_P_W'(remainder[lpg_pkg::PROD_W-1:lpg_pkg::REC_DROP])
	                * lpg_pkg::REC_P_W'(lpg_pkg::RECIP_125);

	assign next_phase = phase_q + lpg_pkg::PHASE_W'(1);
	assign same_pat   = (req_pat_q == pat_q) && !flash_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= in_data.action;
			req_pat_q <= in_data.pattern;
			now_q     <= in_data.now_us;
		end
		if (cmd.span_load)
			span_q <= lpg_pkg::PROD_W'(half_eff) * lpg_pkg::PROD_W'(lpg_pkg::US_PER_MS);
		if (cmd.ms_calc)
			ms_q <= rec_prod[lpg_pkg::REC_SH +: lpg_pkg::HALF_W];
		if (cmd.mul)
			prod_q <= lpg_pkg::PROD_W'(ms_q) * lpg_pkg::PROD_W'(lpg_pkg::US_PER_MS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q    <= lpg_pkg::PAT_ON;
			last_q   <= '0;
			led_q    <= 1'b1;
			flash_q  <= 1'b0;
			pulses_q <= '0;
			phase_q  <= '0;
		end else if (cmd.do_select) begin
			if (!same_pat) begin
				pat_q  <= req_pat_q;
				last_q <= now_q;
				case (req_pat_q)
					lpg_pkg::PAT_ON: begin
						flash_q <= 1'b0;
						led_q   <= 1'b1;
					end
					lpg_pkg::PAT_OFF: begin
						flash_q <= 1'b0;
						led_q   <= 1'b0;
					end
					lpg_pkg::PAT_FLASH3: begin
						flash_q  <= 1'b1;
						pulses_q <= lpg_pkg::PULSES_FLASH3;
						phase_q  <= '0;
						led_q    <= 1'b0;
					end
					lpg_pkg::PAT_FLASH2: begin
						flash_q  <= 1'b1;
						pulses_q <= lpg_pkg::PULSES_FLASH2;
						phase_q  <= '0;
						led_q    <= 1'b0;
					end
					default: begin
						flash_q <= 1'b0;
						led_q   <= 1'b1;
					end
				endcase
			end
		end else if (cmd.flash_step) begin
			last_q  <= now_q;
			phase_q <= next_phase;
			if (next_phase[0]) begin
				led_q <= 1'b1;
			end else if (next_phase[lpg_pkg::PHASE_W-1:1] >= pulses_q) begin
				// sequence over: fall back to solid on
				flash_q <= 1'b0;
				pat_q   <= lpg_pkg::PAT_ON;
				led_q   <= 1'b1;
			end else begin
				led_q <= 1'b0;
			end
		end else if (cmd.toggle) begin
			// keep the leftover so the blink does not drift
			last_q <= now_q - lpg_pkg::TIME_BITS'(prod_q);
			led_q  <= !led_q;
		end
	end

	assign status.action     = act_q;
	assign status.is_static  = !flash_q
	                         && (pat_q == lpg_pkg::PAT_ON || pat_q == lpg_pkg::PAT_OFF);
	assign status.in_flash   = flash_q;
	assign status.div_done   = div_done;
	assign status.elapsed_ge = (diff >= lpg_pkg::TIME_BITS'(span_q));
	assign status.out_free   = 1'b0;

	assign result.led_on         = led_q;
	assign result.active_pattern = pat_q;
	assign result.flashing       = flash_q;

endmodule

// ===== rtl/lpg_ctrl.sv =====
module lpg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lpg_pkg::status_t  status,
	output lpg_pkg::cmd_t     cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_DIV    = 8'b0000_1000,
		S_RECIP  = 8'b0001_0000,
		S_MUL    = 8'b0010_0000,
		S_TOGGLE = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (status.action == lpg_pkg::ACT_SELECT) begin
					cmd.do_select = 1'b1;
					state_d       = S_FINISH;
				end else if (status.is_static) begin
					state_d = S_FINISH;
				end else begin
					cmd.span_load = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!status.elapsed_ge) begin
					state_d = S_FINISH;
				end else if (status.in_flash) begin
					cmd.flash_step = 1'b1;
					state_d        = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done)
					state_d = S_RECIP;
			end
			S_RECIP: begin
				cmd.ms_calc = 1'b1;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_TOGGLE;
			end
			S_TOGGLE: begin
				cmd.toggle = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule
